### hw/rtl/ii_pkg.sv
// ----------------------------------------------------------------------------
// ii_pkg
// Shared constants, types and helpers for the integral image block.
// ----------------------------------------------------------------------------
package ii_pkg;

  // Default sizes handed to the top level
  localparam int MAX_COLS_DEF     = 1024;
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Datapath widths: row running sum and summed-area value wrap here
  localparam int RUN_W = 26;
  localparam int SUM_W = 36;

  // Configuration port layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Count written to both size registers at reset
  localparam logic [CFG_DATA_W-1:0] RESET_COUNT = 11'd1024;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1
  } reg_idx_t;

  // Position flags that travel with an item into the merge stage
  typedef struct packed {
    logic row_nz;     // item is below row 0, so the line store is used
    logic frame_end;  // item is the last position of the frame
  } pos_ctl_t;

  // Zero counts as one, anything above the maximum saturates
  function automatic int unsigned clamp_count(logic [CFG_DATA_W-1:0] v,
                                              int unsigned maxv);
    int unsigned r;
    if (v == '0) begin
      r = 1;
    end else if (int'(v) > int'(maxv)) begin
      r = maxv;
    end else begin
      r = int'(v);
    end
    return r;
  endfunction

endpackage

### hw/rtl/ii_sample_if.sv
// ----------------------------------------------------------------------------
// ii_sample_if
// Input sample channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface ii_sample_if #(
  parameter int SAMPLE_WIDTH = ii_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

### hw/rtl/ii_result_if.sv
// ----------------------------------------------------------------------------
// ii_result_if
// Result channel: valid/ready handshake with the summed-area value.
// ----------------------------------------------------------------------------
interface ii_result_if #(
  parameter int SUM_W = ii_pkg::SUM_W
);
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] area_sum;
  logic                    frame_end;

  modport source (output valid, output area_sum, output frame_end, input ready);
  modport sink   (input valid, input area_sum, input frame_end, output ready);
endinterface

### hw/rtl/ii_cfg_if.sv
// ----------------------------------------------------------------------------
// ii_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ii_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ii_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [ii_pkg::CFG_DATA_W-1:0]  reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

### hw/rtl/ii_ram.sv
// ----------------------------------------------------------------------------
// ii_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ii_ram #(
  parameter int WIDTH  = 36,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in code order; a same-address read returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ii_scan.sv
// ----------------------------------------------------------------------------
// ii_scan
// Raster position counters, size registers and the row running sum.
// ----------------------------------------------------------------------------
module ii_scan #(
  parameter int MAX_COLS     = ii_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = ii_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_WIDTH = ii_pkg::SAMPLE_WIDTH_DEF,
  parameter int COL_W        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  parameter int RUN_W        = ii_pkg::RUN_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_value,
  input  logic                            cfg_we,
  input  logic [ii_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ii_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [COL_W-1:0]                col,
  output logic signed [RUN_W-1:0]         run_new,
  output ii_pkg::pos_ctl_t                ctl
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_C = $clog2(MAX_COLS + 1);
  localparam int CNT_R = $clog2(MAX_ROWS + 1);

  logic [CNT_C-1:0]        cols;
  logic [CNT_R-1:0]        rows;
  logic [ROW_W-1:0]        row;
  logic signed [RUN_W-1:0] run_sum;
  logic signed [RUN_W-1:0] x_ext;
  logic                    last_col;
  logic                    last_row;

  // End-of-row / end-of-frame detection
  assign last_col = (CNT_C'(col) + CNT_C'(1)) >= cols;
  assign last_row = (CNT_R'(row) + CNT_R'(1)) >= rows;

  // Running sum restarts at the first column
  assign x_ext   = RUN_W'(sample_value);
  assign run_new = (col == '0) ? x_ext : run_sum + x_ext;

  assign ctl.row_nz    = (row != '0);
  assign ctl.frame_end = last_col && last_row;

  // Size registers and raster position; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      cols    <= CNT_C'(ii_pkg::clamp_count(ii_pkg::RESET_COUNT, MAX_COLS));
      rows    <= CNT_R'(ii_pkg::clamp_count(ii_pkg::RESET_COUNT, MAX_ROWS));
      col     <= '0;
      row     <= '0;
      run_sum <= '0;
    end else if (cfg_we) begin
      unique case (ii_pkg::reg_idx_t'(cfg_index))
        ii_pkg::REG_COLS: begin
          cols    <= CNT_C'(ii_pkg::clamp_count(cfg_data, MAX_COLS));
          col     <= '0;
          row     <= '0;
          run_sum <= '0;
        end
        ii_pkg::REG_ROWS: begin
          rows    <= CNT_R'(ii_pkg::clamp_count(cfg_data, MAX_ROWS));
          col     <= '0;
          row     <= '0;
          run_sum <= '0;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      run_sum <= run_new;
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // A frame-end transaction wraps the position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    take && !cfg_we && ctl.frame_end |=> col == '0 && row == '0)
    else $error("position did not wrap after frame end");

  // Inside a row the column steps by one
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    take && !cfg_we && !last_col |=> col == $past(col) + COL_W'(1) && row == $past(row))
    else $error("column did not advance by one");

endmodule

### hw/rtl/ii_join.sv
// ----------------------------------------------------------------------------
// ii_join
// Adds the line-store value to the running sum, writes it back and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module ii_join #(
  parameter int COL_W = 10,
  parameter int RUN_W = 26,
  parameter int SUM_W = 36
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [COL_W-1:0]        col_in,
  input  logic signed [RUN_W-1:0] run_in,
  input  ii_pkg::pos_ctl_t        ctl_in,
  output logic                    s1_ready,
  input  logic [SUM_W-1:0]        rd_data,
  output logic                    wr_en,
  output logic [COL_W-1:0]        wr_addr,
  output logic [SUM_W-1:0]        wr_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] area_sum,
  output logic                    frame_end
);

  logic                    s1_valid;
  logic [COL_W-1:0]        s1_col;
  logic signed [RUN_W-1:0] s1_run;
  ii_pkg::pos_ctl_t        s1_ctl;
  logic                    fwd_hit;
  logic [SUM_W-1:0]        fwd_data;
  logic                    out_free;
  logic                    s1_adv;
  logic [SUM_W-1:0]        above;
  logic [SUM_W-1:0]        sum;

  // Handshake between merge stage and output register
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign s1_ready = !s1_valid || out_free;

  // Forwarded word covers a read issued while the same entry was written
  assign above = fwd_hit ? fwd_data : rd_data;
  assign sum   = SUM_W'(s1_run) + (s1_ctl.row_nz ? above : '0);

  // Write-back into the line store as the item leaves the stage
  assign wr_en   = s1_adv;
  assign wr_addr = s1_col;
  assign wr_data = sum;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_col   <= col_in;
      s1_run   <= run_in;
      s1_ctl   <= ctl_in;
      fwd_hit  <= s1_adv && (s1_col == col_in);
      fwd_data <= sum;
    end
    if (s1_adv) begin
      area_sum  <= sum;
      frame_end <= s1_ctl.frame_end;
    end
  end

  // A stalled merge stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_col) && $stable(s1_run))
    else $error("merge stage lost its item under stall");

  // The written-back word is the one presented
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid && area_sum == $past(sum))
    else $error("output register does not match written-back sum");

endmodule

### hw/rtl/integral_image.sv
// ----------------------------------------------------------------------------
// integral_image
// Streaming summed-area table over a raster-order sample stream.
// ----------------------------------------------------------------------------
// Channels: "sample" carries one signed sample per transaction in raster
// order; "result" returns one summed-area value per sample, with frame_end
// set on the last position of the frame; "cfg" writes the column count
// (index 0) and row count (index 1). Zero counts as one and larger values
// saturate at MAX_COLS / MAX_ROWS. A register write restarts the frame at
// the origin and keeps the line store; cfg is always ready.
// Throughput: one sample per cycle while result is not stalled, set by the
// single line-store RAM that takes one read and one write each cycle.
// Path: an accepted sample's RAM read is registered with it into the merge
// stage; the add and write-back then load the output register.
// A same-entry read and write in the same cycle (single column) is forwarded.
// Reset: sizes return to 1024 x 1024, position to the origin; the line
// store needs no clearing since row 0 ignores what it reads.
// Stall: when the receiver holds ready low, the output register and the
// merge stage fill, and then sample.ready drops until result drains.
// ----------------------------------------------------------------------------
module integral_image #(
  parameter int MAX_COLS     = ii_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = ii_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_WIDTH = ii_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ii_sample_if.sink  sample,
  ii_result_if.source result,
  ii_cfg_if.sink     cfg
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RUN_W = ii_pkg::RUN_W;
  localparam int SUM_W = ii_pkg::SUM_W;

  logic                    take;
  logic                    s1_ready;
  logic                    cfg_we;
  logic [COL_W-1:0]        col;
  logic signed [RUN_W-1:0] run_new;
  ii_pkg::pos_ctl_t        ctl;
  logic [SUM_W-1:0]        rd_data;
  logic                    wr_en;
  logic [COL_W-1:0]        wr_addr;
  logic [SUM_W-1:0]        wr_data;

  // Transaction qualifiers
  assign sample.ready = s1_ready;
  assign take         = sample.valid && s1_ready;
  assign cfg.ready    = 1'b1;
  assign cfg_we       = cfg.valid;

  // Position tracking and running sum
  ii_scan #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COL_W        (COL_W),
    .RUN_W        (RUN_W)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .sample_value (sample.sample_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg.reg_index),
    .cfg_data     (cfg.reg_data),
    .col          (col),
    .run_new      (run_new),
    .ctl          (ctl)
  );

  // Line store of the previous row's integrals
  ii_ram #(
    .WIDTH  (SUM_W),
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (take),
    .raddr (col),
    .rdata (rd_data)
  );

  // Merge, write-back and output register
  ii_join #(
    .COL_W (COL_W),
    .RUN_W (RUN_W),
    .SUM_W (SUM_W)
  ) u_join (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .col_in    (col),
    .run_in    (run_new),
    .ctl_in    (ctl),
    .s1_ready  (s1_ready),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .area_sum  (result.area_sum),
    .frame_end (result.frame_end)
  );

endmodule

### dv/ii_area_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ii_area_checker
// Watches the sample, result and cfg channels of integral_image. It keeps its
// own running row sum, line store and raster position, works out the
// summed-area value and frame mark of every accepted sample, and compares each
// returned result, field by field, with the oldest value still due.
// ----------------------------------------------------------------------------
module ii_area_checker (
  input  logic  clk,
  input  logic  rst,
  ii_sample_if  sample,
  ii_result_if  result,
  ii_cfg_if     cfg,
  output int    fail_count,
  output int    results_due
);

  localparam int unsigned LINE_LEN = ii_pkg::MAX_COLS_DEF;
  localparam int unsigned ROW_LIM  = ii_pkg::MAX_ROWS_DEF;

  typedef struct packed {
    logic signed [35:0] area_sum;
    logic               frame_end;
  } area_exp_t;

  area_exp_t          area_exp_q[$];
  int unsigned        cols_now;
  int unsigned        rows_now;
  logic signed [25:0] row_acc;
  logic signed [35:0] line_store [LINE_LEN];
  int unsigned        col_pos;
  int unsigned        row_pos;

  // Size register decode: zero means one, large values saturate
  function automatic int unsigned size_from_reg(logic [ii_pkg::CFG_DATA_W-1:0] v,
                                                int unsigned lim);
    return (v == '0) ? 1 : ((32'(v) > lim) ? lim : 32'(v));
  endfunction

  function automatic void restart_origin();
    row_acc = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Summed-area value of one sample, by the row-sum plus row-above recurrence
  function automatic area_exp_t area_of_sample(logic signed [15:0] x);
    logic signed [25:0] x_wide;
    logic signed [25:0] acc;
    logic signed [35:0] acc_wide;
    logic signed [35:0] above;
    logic signed [35:0] total;
    logic               last_col;
    logic               last_row;
    area_exp_t          e;
    x_wide   = x;
    acc      = (col_pos == 0) ? x_wide : row_acc + x_wide;
    acc_wide = acc;
    above    = (row_pos != 0) ? line_store[col_pos] : '0;
    total    = acc_wide + above;
    line_store[col_pos] = total;
    row_acc  = acc;
    last_col = (col_pos + 1 >= cols_now);
    last_row = (row_pos + 1 >= rows_now);
    e.area_sum  = total;
    e.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_acc = '0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    int        errs;
    area_exp_t e;
    errs = 0;
    if (rst) begin
      cols_now = size_from_reg(ii_pkg::RESET_COUNT, LINE_LEN);
      rows_now = size_from_reg(ii_pkg::RESET_COUNT, ROW_LIM);
      restart_origin();
      area_exp_q.delete();
    end else begin
      // Result transaction: compare with the oldest expectation
      if (result.valid && result.ready) begin
        if (area_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got area_sum %0d frame_end %0b",
                   $time, result.area_sum, result.frame_end);
          errs++;
        end else begin
          e = area_exp_q.pop_front();
          if (result.area_sum !== e.area_sum) begin
            $display("%0t: area_sum expected %0d, got %0d",
                     $time, e.area_sum, result.area_sum);
            errs++;
          end
          if (result.frame_end !== e.frame_end) begin
            $display("%0t: frame_end expected %0b, got %0b",
                     $time, e.frame_end, result.frame_end);
            errs++;
          end
        end
      end
      // Register write: new size, frame restarts, line store kept
      if (cfg.valid && cfg.ready) begin
        if (cfg.reg_index == ii_pkg::REG_COLS) begin
          cols_now = size_from_reg(cfg.reg_data, LINE_LEN);
          restart_origin();
        end else if (cfg.reg_index == ii_pkg::REG_ROWS) begin
          rows_now = size_from_reg(cfg.reg_data, ROW_LIM);
          restart_origin();
        end
      end
      // Sample transaction: predict its result
      if (sample.valid && sample.ready) begin
        area_exp_q.push_back(area_of_sample(sample.sample_value));
      end
    end
    fail_count  <= fail_count + errs;
    results_due <= area_exp_q.size();
  end

endmodule

### dv/tb_integral_image.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integral_image
// Drives raster-order samples and size register writes into integral_image,
// with random idle bursts on the sample and result sides, one long result
// hold-off and full drains. A checker beside the block predicts and checks
// every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_integral_image;

  localparam int SMALL_ITEMS  = 640;
  localparam int TAIL_ITEMS   = 150;
  localparam int TALL_ITEMS   = 64;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_PHASE    = 48;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;
  // Register indexes with no register behind them
  localparam logic [ii_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [ii_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk;
  logic rst;
  logic quiet_tail;
  logic rx_hold_req;
  int   fails;
  int   results_due;
  int   small_sent;

  ii_sample_if #(.SAMPLE_WIDTH(ii_pkg::SAMPLE_WIDTH_DEF)) sample_ch ();
  ii_result_if                                            result_ch ();
  ii_cfg_if                                               cfg_ch ();

  integral_image i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  ii_area_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .fail_count  (fails),
    .results_due (results_due)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none at the tail
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_tail) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // One sample transaction, with an optional idle burst ahead of it
  task automatic send_sample(input logic signed [15:0] v);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= v;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Stop sending and wait until every result due has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [ii_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ii_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 11);
    case (r)
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly small sizes; zero and oversize values now and then
  function automatic logic [ii_pkg::CFG_DATA_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 4) return ii_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
    if (r < 6) return ii_pkg::CFG_DATA_W'($urandom_range(9, 64));
    return ii_pkg::CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  initial begin
    logic [ii_pkg::CFG_DATA_W-1:0] cols_w;
    logic [ii_pkg::CFG_DATA_W-1:0] rows_w;
    longint                        frame_len;
    int                            n;
    int                            pause_at;
    bit                            hold_used;

    rst                    <= 1'b1;
    quiet_tail             <= 1'b0;
    rx_hold_req            <= 1'b0;
    sample_ch.valid        <= 1'b0;
    sample_ch.sample_value <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.reg_index       <= ii_pkg::REG_COLS;
    cfg_ch.reg_data        <= '0;
    small_sent = 0;
    hold_used  = 0;
    cols_w     = ii_pkg::RESET_COUNT;
    rows_w     = ii_pkg::RESET_COUNT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes, first row of a 1024 x 1024 frame
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd0);

    // Zero sizes count as one: every sample ends a frame
    write_reg(ii_pkg::REG_COLS, '0);
    write_reg(ii_pkg::REG_ROWS, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(-16'sd1);

    // 3 x 2 frames at the sample extremes, row above read back
    write_reg(ii_pkg::REG_COLS, 11'd3);
    write_reg(ii_pkg::REG_ROWS, 11'd2);
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);
    repeat (3) send_sample(SAMPLE_MIN);
    // Writes to spare indexes leave the frame position alone
    send_sample(-16'sd1);
    write_reg(REG_SPARE_2, 11'h7ff);
    send_sample(16'sd1);
    write_reg(REG_SPARE_3, 11'h555);
    send_sample(SAMPLE_MAX);
    // Rewriting a size mid-frame restarts at the origin
    send_sample(16'sd7);
    write_reg(ii_pkg::REG_COLS, 11'd3);
    repeat (4) send_sample(pick_sample());

    // Widest row: oversize column count saturates, column counter wraps
    write_reg(ii_pkg::REG_COLS, 11'h7ff);
    write_reg(ii_pkg::REG_ROWS, 11'd1);
    repeat (1025) send_sample(pick_sample());

    // One column, oversize row count: each sample reads the entry just written
    write_reg(ii_pkg::REG_COLS, 11'd1);
    write_reg(ii_pkg::REG_ROWS, 11'h7ff);
    repeat (TALL_ITEMS) send_sample(pick_sample());

    // Random phases of mostly small frames
    while (small_sent < SMALL_ITEMS) begin
      if (small_sent == 0 || $urandom_range(0, 3) != 0) begin
        cols_w = pick_size();
        rows_w = pick_size();
        write_reg(ii_pkg::REG_COLS, cols_w);
        write_reg(ii_pkg::REG_ROWS, rows_w);
      end
      if ($urandom_range(0, 15) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                  ii_pkg::CFG_DATA_W'($urandom()));
      end
      frame_len = longint'((cols_w == 0) ? 1 : cols_w) * longint'((rows_w == 0) ? 1 : rows_w);
      n = (2 * frame_len + 1 > MAX_PHASE) ? MAX_PHASE : int'(2 * frame_len + 1);
      n = $urandom_range(1, n);
      pause_at = -1;
      if (!hold_used && small_sent > 200) begin
        // Receiver holds off while samples keep coming
        hold_used = 1;
        n = MAX_PHASE;
        rx_hold_req <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        pause_at = n / 2;
      end
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) drain_results();
        send_sample(pick_sample());
        small_sent++;
      end
      if (small_sent >= SMALL_ITEMS - TAIL_ITEMS) quiet_tail <= 1'b1;
    end

    // Let everything come back, then the pipeline settle
    drain_results();
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
